@@ rtl/bba_pkg.sv @@
package bba_pkg;

    // Map geometry
    localparam int BLOCKS    = 4096;
    localparam int WORD_W    = 64;
    localparam int MAP_WORDS = (BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int GRP_W     = 8;
    localparam int GRPS      = WORD_W / GRP_W;

    // Field widths
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam int STS_W = 2;

    localparam logic [CNT_W-1:0] BLOCKS_CNT = CNT_W'(BLOCKS);
    localparam logic [CNT_W-1:0] WORD_CNT   = CNT_W'(WORD_W);

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [STS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STS_W-1:0] STAT_FULL        = 2'd1;
    localparam logic [STS_W-1:0] STAT_DOUBLE_FREE = 2'd2;
    localparam logic [STS_W-1:0] STAT_RANGE       = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SCAN     = 4'b0010,
        ST_FREE_CHK = 4'b0100,
        ST_EMIT     = 4'b1000
    } state_t;

    // Outcome of one word through the scan unit
    typedef struct packed {
        logic             hit;
        logic             last;
        logic [BIT_W-1:0] bit_pos;
    } scan_res_t;

endpackage

@@ rtl/bba_ram.sv @@
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/bba_scan.sv @@
module bba_scan (
    input  logic [bba_pkg::WORD_W-1:0]  word,
    input  logic [bba_pkg::WADDR_W-1:0] word_idx,
    input  logic [bba_pkg::CNT_W-1:0]   limit,
    output bba_pkg::scan_res_t          res
);

    logic [bba_pkg::CNT_W-1:0]  base;
    logic [bba_pkg::CNT_W-1:0]  span;
    logic [bba_pkg::WORD_W-1:0] avail;
    logic [bba_pkg::GRPS-1:0]   grp_any;
    logic [$clog2(bba_pkg::GRPS)-1:0]  grp_sel;
    logic [$clog2(bba_pkg::GRP_W)-1:0] bit_sel;
    logic [bba_pkg::GRP_W-1:0]  grp_bits;

    assign base = bba_pkg::CNT_W'({word_idx, bba_pkg::BIT_W'(0)});
    assign span = limit - base;

    // Free bits of this word that lie below the limit
    always_comb begin
        for (int i = 0; i < bba_pkg::WORD_W; i++) begin
            avail[i] = ~word[i] && (bba_pkg::CNT_W'(i) < span);
        end
    end

    // First free bit: pick the lowest nonempty byte, then the lowest bit in it
    always_comb begin
        grp_sel = '0;
        for (int g = bba_pkg::GRPS - 1; g >= 0; g--) begin
            grp_any[g] = |avail[g*bba_pkg::GRP_W +: bba_pkg::GRP_W];
        end
        for (int g = bba_pkg::GRPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                grp_sel = ($clog2(bba_pkg::GRPS))'(g);
            end
        end
    end

    assign grp_bits = avail[grp_sel*bba_pkg::GRP_W +: bba_pkg::GRP_W];

    always_comb begin
        bit_sel = '0;
        for (int b = bba_pkg::GRP_W - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                bit_sel = ($clog2(bba_pkg::GRP_W))'(b);
            end
        end
    end

    assign res.hit     = |grp_any;
    assign res.last    = (span <= bba_pkg::WORD_CNT);
    assign res.bit_pos = {grp_sel, bit_sel};

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// Flow: an allocate scans the usage map word by word, up to 64 words; a free reads
//   one word and rewrites it unless the block is already free; an out-of-range free
//   or an allocate with zero blocks skips the map. One request at a time is taken;
//   the usage RAM read, one 64-bit word a cycle, paces the scan.
// Reset: total_blocks returns to 4096, the 64 row-valid bits clear so every block
//   reads free at once (no clearing pass), and both channels go idle.
module bitmap_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,   // total_blocks

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [11:0] block_index, [15:12] zero
    input  logic        s_tuser,       // [0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [11:0] result_index, [15:12] zero
    output logic [1:0]  m_tuser        // [1:0] status
);

    // ------------------------------------------------------------------
    // Configuration register and effective block count
    // ------------------------------------------------------------------
    logic [bba_pkg::CNT_W-1:0] total_blocks_reg;
    logic [bba_pkg::CNT_W-1:0] limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_blocks_reg <= bba_pkg::BLOCKS_CNT;
        end else if (cfg_wr_en) begin
            total_blocks_reg <= cfg_wr_data;
        end
    end

    // Saturate the count at the map size
    assign limit = (total_blocks_reg > bba_pkg::BLOCKS_CNT) ? bba_pkg::BLOCKS_CNT
                                                            : total_blocks_reg;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    bba_pkg::state_t state_reg, state_next;

    logic [bba_pkg::WADDR_W-1:0] chk_w_reg, chk_w_next;     // word under check
    logic [bba_pkg::IDX_W-1:0]   idx_reg, idx_next;         // block to free
    logic [bba_pkg::STS_W-1:0]   res_status_reg, res_status_next;
    logic [bba_pkg::IDX_W-1:0]   res_index_reg, res_index_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [bba_pkg::STS_W-1:0]   m_status_reg, m_status_next;
    logic [bba_pkg::IDX_W-1:0]   m_index_reg, m_index_next;

    // Row-valid bits: a row not yet written reads as all free
    logic [bba_pkg::MAP_WORDS-1:0] row_vld_reg, row_vld_next;
    logic                          rd_vld_reg, rd_vld_next;

    // Usage RAM ports
    logic                        ram_wr_en;
    logic [bba_pkg::WADDR_W-1:0] ram_wr_addr;
    logic [bba_pkg::WORD_W-1:0]  ram_wr_data;
    logic                        ram_rd_en;
    logic [bba_pkg::WADDR_W-1:0] ram_rd_addr;
    logic [bba_pkg::WORD_W-1:0]  ram_rd_data;

    logic [bba_pkg::WORD_W-1:0]  cur_word;
    logic [bba_pkg::BIT_W-1:0]   free_bit;
    logic                        in_accept;
    logic                        out_free;
    bba_pkg::scan_res_t          scan_res;

    bba_ram #(
        .WIDTH (bba_pkg::WORD_W),
        .DEPTH (bba_pkg::MAP_WORDS)
    ) u_usage_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Mask out rows never written since reset
    assign cur_word = rd_vld_reg ? ram_rd_data : '0;

    // Scan unit for allocates: mask the word to the limit and find its first free bit
    bba_scan u_scan (
        .word     (cur_word),
        .word_idx (chk_w_reg),
        .limit    (limit),
        .res      (scan_res)
    );

    assign free_bit  = idx_reg[bba_pkg::BIT_W-1:0];
    assign s_tready  = (state_reg == bba_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        chk_w_next      = chk_w_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        row_vld_next    = row_vld_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = chk_w_reg;
        ram_wr_data = cur_word;
        ram_rd_en   = 1'b0;
        ram_rd_addr = chk_w_reg + 1'b1;

        // Drop the output beat once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            bba_pkg::ST_IDLE: begin
                if (in_accept) begin
                    idx_next       = s_tdata[bba_pkg::IDX_W-1:0];
                    res_index_next = '0;
                    if (s_tuser == bba_pkg::REQ_ALLOC) begin
                        if (limit == '0) begin
                            res_status_next = bba_pkg::STAT_FULL;
                            state_next      = bba_pkg::ST_EMIT;
                        end else begin
                            // Fetch word 0 and start the scan
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            chk_w_next  = '0;
                            state_next  = bba_pkg::ST_SCAN;
                        end
                    end else begin
                        if ({1'b0, s_tdata[bba_pkg::IDX_W-1:0]} >= limit) begin
                            res_status_next = bba_pkg::STAT_RANGE;
                            state_next      = bba_pkg::ST_EMIT;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = s_tdata[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                            state_next  = bba_pkg::ST_FREE_CHK;
                        end
                    end
                end
            end

            bba_pkg::ST_SCAN: begin
                // Prefetch the following word while this one is checked
                ram_rd_en = 1'b1;
                priority if (scan_res.hit) begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = chk_w_reg;
                    ram_wr_data     = cur_word
                                      | (bba_pkg::WORD_W'(1) << scan_res.bit_pos);
                    row_vld_next[chk_w_reg] = 1'b1;
                    res_status_next = bba_pkg::STAT_OK;
                    res_index_next  = {chk_w_reg, scan_res.bit_pos};
                    state_next      = bba_pkg::ST_EMIT;
                end else if (scan_res.last) begin
                    res_status_next = bba_pkg::STAT_FULL;
                    state_next      = bba_pkg::ST_EMIT;
                end else begin
                    chk_w_next = chk_w_reg + 1'b1;
                end
            end

            bba_pkg::ST_FREE_CHK: begin
                if (!cur_word[free_bit]) begin
                    res_status_next = bba_pkg::STAT_DOUBLE_FREE;
                end else begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = idx_reg[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                    ram_wr_data     = cur_word & ~(bba_pkg::WORD_W'(1) << free_bit);
                    row_vld_next[idx_reg[bba_pkg::IDX_W-1:bba_pkg::BIT_W]] = 1'b1;
                    res_status_next = bba_pkg::STAT_OK;
                end
                state_next = bba_pkg::ST_EMIT;
            end

            bba_pkg::ST_EMIT: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    state_next    = bba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase

        rd_vld_next = ram_rd_en ? row_vld_next[ram_rd_addr] && row_vld_reg[ram_rd_addr]
                                : rd_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bba_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            row_vld_reg  <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            row_vld_reg  <= row_vld_next;
            rd_vld_reg   <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_w_reg      <= chk_w_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(16 - bba_pkg::IDX_W){1'b0}}, m_index_reg};

`ifndef SYNTHESIS
    // One item at a time: the input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted a second beat while busy");

    // Any map update ends the item's work
    a_write_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |=> state_reg == bba_pkg::ST_EMIT)
        else $error("usage map written without finishing the item");

    // Failed requests carry a zero index
    a_fail_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != bba_pkg::STAT_OK |-> m_tdata == 16'd0)
        else $error("nonzero index on a failed request");

    // A result is produced only by a finishing item
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == bba_pkg::ST_EMIT)
        else $error("result beat without a finished item");
`endif

endmodule
